// File: rtl/ffac_pkg.sv
`timescale 1ns / 1ps
package ffac_pkg;

   // Build defaults
   localparam int POOL_CELLS_DEF  = 128;
   localparam int HANDLE_BITS_DEF = 16;

   // Field widths of the words on the ports
   localparam int OPCODE_BITS    = 2;
   localparam int AMOUNT_BITS    = 8;
   localparam int HANDLE_W       = 16;
   localparam int STATUS_BITS    = 2;
   localparam int POOL_SIZE_BITS = 8;

   // Configuration port
   localparam int                  CSR_ADDR_BITS   = 3;
   localparam int                  CSR_DATA_BITS   = 32;
   localparam logic                REG_POOL_SIZE   = 1'b0;
   localparam logic [POOL_SIZE_BITS-1:0] POOL_SIZE_RESET = 8'd128;

   // Opcodes
   localparam logic [OPCODE_BITS-1:0] OP_ALLOC  = 2'd0;
   localparam logic [OPCODE_BITS-1:0] OP_ERASE  = 2'd1;
   localparam logic [OPCODE_BITS-1:0] OP_DEFRAG = 2'd2;

   // Result status codes
   localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
   localparam logic [STATUS_BITS-1:0] ST_NOSPACE = 2'd1;
   localparam logic [STATUS_BITS-1:0] ST_ILLEGAL = 2'd2;

   typedef struct packed {
      logic [OPCODE_BITS-1:0] opcode;
      logic [AMOUNT_BITS-1:0] amount;
      logic [HANDLE_W-1:0]    handle;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [HANDLE_W-1:0]    new_handle;
   } rsp_word_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ALLOC_SCAN,
      S_ALLOC_WRITE,
      S_ERASE_SCAN,
      S_DEFRAG_SCAN,
      S_ZERO
   } ffac_state_type;

endpackage

// File: rtl/first_fit_allocator_with_compaction.sv
`timescale 1ns / 1ps
// First-fit cell allocator with compaction.
// Request channel: drive req_word with start; the word is taken at a clock
// edge where start is high and busy is low. Opcodes: alloc (amount cells),
// erase (handle), defragment. Result channel: rsp_strobe is high for one
// cycle with rsp_word (status, new_handle); the receiver cannot stall it.
// An alloc always answers; an erase answers only when illegal; a
// defragment never answers.
// With N the built pool depth and L the usable pool size: an alloc rejected
// at once, or an erase of handle 0, gives a registered result; an alloc
// searches up to L cells and then writes amount cells; an erase scans all N
// cells; a defragment scans all N cells and then clears the N - live cells.
// All cost comes from the single owner RAM, one cell read per cycle and one
// write per cycle. One request is in work at a time; busy covers it.
// Reset sets the handle counter to 1 and runs a clearing pass over all N cells
// of the owner RAM with busy high; configuration writes are taken anytime.
// pool_size lives at byte address 0 of the register port.
module first_fit_allocator_with_compaction
   import ffac_pkg::*;
#(
   parameter int POOL_CELLS  = POOL_CELLS_DEF,
   parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  req_word_type             req_word,
   output logic                     rsp_strobe,
   output rsp_word_type             rsp_word,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   logic [POOL_SIZE_BITS-1:0] pool_size_ff, pool_size_in;
   logic                      csr_write;

   // Register port: write pool_size on the access cycle
   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready && (paddr[2] == REG_POOL_SIZE);

   always_comb begin
      pool_size_in = pool_size_ff;
      if (csr_write) begin
         pool_size_in = pwdata[POOL_SIZE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_size_ff <= POOL_SIZE_RESET;
      end else begin
         pool_size_ff <= pool_size_in;
      end
   end

   assign prdata = (paddr[2] == REG_POOL_SIZE) ? CSR_DATA_BITS'(pool_size_ff) : '0;

   ffac_engine #(
      .POOL_CELLS  (POOL_CELLS),
      .HANDLE_BITS (HANDLE_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_word   (req_word),
      .pool_size  (pool_size_ff),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   // Reset always starts the clearing pass
   a_reset_clears : assert property (@(posedge clock) reset |=> busy)
      else $error("clearing pass not started after reset");

   // A result only follows an accepted word or work in progress
   a_rsp_has_cause : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> ($past(busy) || $past(start)))
      else $error("result word without a request");

   // Failed requests carry no handle
   a_fail_no_handle : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_word.status != ST_OK) |-> (rsp_word.new_handle == '0))
      else $error("failed result carries a handle");

endmodule

// File: rtl/ffac_ram.sv
`timescale 1ns / 1ps
module ffac_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 128,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write one entry, read one entry with registered data
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/ffac_engine.sv
`timescale 1ns / 1ps
module ffac_engine
   import ffac_pkg::*;
#(
   parameter int POOL_CELLS  = POOL_CELLS_DEF,
   parameter int HANDLE_BITS = HANDLE_BITS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  req_word_type              req_word,
   input  logic [POOL_SIZE_BITS-1:0] pool_size,
   output logic                      busy,
   output logic                      rsp_strobe,
   output rsp_word_type              rsp_word
);

   localparam int AW       = (POOL_CELLS > 1) ? $clog2(POOL_CELLS) : 1;
   localparam int CW       = $clog2(POOL_CELLS + 1);
   localparam int LW       = (CW > POOL_SIZE_BITS) ? CW : POOL_SIZE_BITS;
   localparam int CMP_BITS = (HANDLE_BITS > HANDLE_W) ? HANDLE_BITS : HANDLE_W;

   ffac_state_type           state_ff, state_in;
   logic [LW-1:0]            scan_ff, scan_in;
   logic [LW-1:0]            bound_ff, bound_in;
   logic                     dvalid_ff, dvalid_in;
   logic [LW-1:0]            didx_ff, didx_in;
   logic [AMOUNT_BITS-1:0]   run_ff, run_in;
   logic [LW-1:0]            end_ff, end_in;
   logic [LW-1:0]            dst_ff, dst_in;
   logic                     found_ff, found_in;
   logic [AMOUNT_BITS-1:0]   amount_ff, amount_in;
   logic [HANDLE_W-1:0]      handle_ff, handle_in;
   logic [HANDLE_BITS:0]     next_ff, next_in;
   logic                     rsp_strobe_ff, rsp_strobe_in;
   rsp_word_type             rsp_word_ff, rsp_word_in;

   logic                     mem_we;
   logic [AW-1:0]            mem_waddr;
   logic [HANDLE_BITS-1:0]   mem_wdata;
   logic [AW-1:0]            mem_raddr;
   logic [HANDLE_BITS-1:0]   mem_rdata;

   logic [LW-1:0]            limit;
   logic                     issue;
   logic                     cell_free;
   logic                     hit;
   logic [AMOUNT_BITS-1:0]   run_next;

   ffac_ram #(
      .WIDTH (HANDLE_BITS),
      .DEPTH (POOL_CELLS)
   ) u_owner_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   // Usable cells: configured size clipped to the built depth
   assign limit = (LW'(pool_size) > LW'(POOL_CELLS)) ? LW'(POOL_CELLS) : LW'(pool_size);

   assign cell_free = (mem_rdata == '0);
   assign hit       = dvalid_ff && (CMP_BITS'(mem_rdata) == CMP_BITS'(handle_ff));
   assign run_next  = cell_free ? AMOUNT_BITS'(run_ff + 1'b1) : '0;
   assign issue     = (scan_ff != bound_ff);

   // Next state, memory requests and results
   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      bound_in      = bound_ff;
      dvalid_in     = 1'b0;
      didx_in       = scan_ff;
      run_in        = run_ff;
      end_in        = end_ff;
      dst_in        = dst_ff;
      found_in      = found_ff;
      amount_in     = amount_ff;
      handle_in     = handle_ff;
      next_in       = next_ff;
      rsp_strobe_in = 1'b0;
      rsp_word_in   = rsp_word_ff;
      mem_we        = 1'b0;
      mem_waddr     = scan_ff[AW-1:0];
      mem_wdata     = '0;
      mem_raddr     = scan_ff[AW-1:0];

      // Advance the read pointer in every scan state
      if ((state_ff == S_ALLOC_SCAN || state_ff == S_ERASE_SCAN ||
           state_ff == S_DEFRAG_SCAN) && issue) begin
         scan_in   = LW'(scan_ff + 1'b1);
         dvalid_in = 1'b1;
         didx_in   = scan_ff;
      end

      case (state_ff)
         S_IDLE: begin
            if (start) begin
               amount_in = req_word.amount;
               handle_in = req_word.handle;
               scan_in   = '0;
               case (req_word.opcode)
                  OP_ALLOC: begin
                     if (req_word.amount == '0 || LW'(req_word.amount) > limit ||
                         next_ff[HANDLE_BITS]) begin
                        rsp_strobe_in = 1'b1;
                        rsp_word_in   = '{status: ST_NOSPACE, new_handle: '0};
                     end else begin
                        bound_in = limit;
                        run_in   = '0;
                        state_in = S_ALLOC_SCAN;
                     end
                  end
                  OP_ERASE: begin
                     if (req_word.handle == '0) begin
                        rsp_strobe_in = 1'b1;
                        rsp_word_in   = '{status: ST_ILLEGAL, new_handle: '0};
                     end else begin
                        bound_in = LW'(POOL_CELLS);
                        found_in = 1'b0;
                        state_in = S_ERASE_SCAN;
                     end
                  end
                  OP_DEFRAG: begin
                     bound_in = LW'(POOL_CELLS);
                     dst_in   = '0;
                     state_in = S_DEFRAG_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Count the free run; stop at the first run long enough
         S_ALLOC_SCAN: begin
            if (dvalid_ff) begin
               run_in = run_next;
            end
            if (dvalid_ff && run_next == amount_ff) begin
               scan_in   = LW'(didx_ff + 1'b1 - LW'(amount_ff));
               end_in    = didx_ff;
               dvalid_in = 1'b0;
               state_in  = S_ALLOC_WRITE;
            end else if (!issue) begin
               rsp_strobe_in = 1'b1;
               rsp_word_in   = '{status: ST_NOSPACE, new_handle: '0};
               state_in      = S_IDLE;
            end
         end

         // Stamp the block with the new handle
         S_ALLOC_WRITE: begin
            mem_we    = 1'b1;
            mem_waddr = scan_ff[AW-1:0];
            mem_wdata = next_ff[HANDLE_BITS-1:0];
            if (scan_ff == end_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_word_in   = '{status: ST_OK,
                                 new_handle: HANDLE_W'(next_ff[HANDLE_BITS-1:0])};
               next_in       = (HANDLE_BITS+1)'(next_ff + 1'b1);
               state_in      = S_IDLE;
            end else begin
               scan_in = LW'(scan_ff + 1'b1);
            end
         end

         // Free every cell of the handle
         S_ERASE_SCAN: begin
            if (hit) begin
               mem_we    = 1'b1;
               mem_waddr = didx_ff[AW-1:0];
               found_in  = 1'b1;
            end
            if (!issue) begin
               if (!(found_ff || hit)) begin
                  rsp_strobe_in = 1'b1;
                  rsp_word_in   = '{status: ST_ILLEGAL, new_handle: '0};
               end
               state_in = S_IDLE;
            end
         end

         // Copy live cells down; the tail is cleared afterwards
         S_DEFRAG_SCAN: begin
            if (dvalid_ff && !cell_free) begin
               mem_we    = 1'b1;
               mem_waddr = dst_ff[AW-1:0];
               mem_wdata = mem_rdata;
               dst_in    = LW'(dst_ff + 1'b1);
            end
            if (!issue) begin
               scan_in  = dst_in;
               state_in = S_ZERO;
            end
         end

         // Clear from the pointer to the top of the pool
         S_ZERO: begin
            if (scan_ff == LW'(POOL_CELLS)) begin
               state_in = S_IDLE;
            end else begin
               mem_we  = 1'b1;
               scan_in = LW'(scan_ff + 1'b1);
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_ZERO;
         scan_ff       <= '0;
         dvalid_ff     <= 1'b0;
         next_ff       <= (HANDLE_BITS+1)'(1);
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_ff       <= scan_in;
         dvalid_ff     <= dvalid_in;
         next_ff       <= next_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      bound_ff    <= bound_in;
      didx_ff     <= didx_in;
      run_ff      <= run_in;
      end_ff      <= end_in;
      dst_ff      <= dst_in;
      found_ff    <= found_in;
      amount_ff   <= amount_in;
      handle_ff   <= handle_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word   = rsp_word_ff;

endmodule
